// File: src/cpualu_pkg.sv
package cpualu_pkg;

    // Operation codes
    localparam logic [3:0] OP_INC   = 4'd0;
    localparam logic [3:0] OP_DEC   = 4'd1;
    localparam logic [3:0] OP_RLCA  = 4'd2;
    localparam logic [3:0] OP_RRCA  = 4'd3;
    localparam logic [3:0] OP_RLA   = 4'd4;
    localparam logic [3:0] OP_RRA   = 4'd5;
    localparam logic [3:0] OP_DAA   = 4'd6;
    localparam logic [3:0] OP_ADD16 = 4'd7;
    localparam logic [3:0] OP_ADD   = 4'd8;
    localparam logic [3:0] OP_ADC   = 4'd9;
    localparam logic [3:0] OP_SUB   = 4'd10;
    localparam logic [3:0] OP_SBC   = 4'd11;
    localparam logic [3:0] OP_AND   = 4'd12;
    localparam logic [3:0] OP_XOR   = 4'd13;
    localparam logic [3:0] OP_OR    = 4'd14;
    localparam logic [3:0] OP_CP    = 4'd15;

    // Cycle costs
    localparam logic [3:0] COST_BYTE = 4'd4;
    localparam logic [3:0] COST_WORD = 4'd8;

    // DAA correction constants
    localparam logic [7:0] DAA_LO  = 8'h06;
    localparam logic [7:0] DAA_HI  = 8'h60;
    localparam logic [7:0] BCD_MAX = 8'h99;
    localparam logic [3:0] BCD_DIG = 4'd9;

    // Flag register layout: zero, subtract, half-carry, carry
    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    // One operation as held in the input stage
    typedef struct packed {
        logic [3:0]  op;
        logic [7:0]  byte_a;
        logic [7:0]  byte_b;
        logic [15:0] word_a;
        logic [15:0] word_b;
    } alu_in_t;

    // One result as held in the output stage
    typedef struct packed {
        logic [7:0]  byte_result;
        logic [15:0] word_result;
        flags_t      flags;
        logic [3:0]  cycle_cost;
    } alu_out_t;

endpackage

// File: src/cpualu_core.sv
module cpualu_core (
    input  cpualu_pkg::alu_in_t  op_in,
    input  cpualu_pkg::flags_t   flags_in,
    output cpualu_pkg::alu_out_t res_out
);

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [8:0]  sum9;
    logic [4:0]  nib5;
    logic [8:0]  dif9;
    logic [4:0]  nibd5;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [7:0]  corr;
    logic [7:0]  daa_r;
    logic [7:0]  r;
    cpualu_pkg::flags_t f;

    assign a = op_in.byte_a;
    assign b = op_in.byte_b;

    // Carry-in only for adc and sbc
    assign cin = ((op_in.op == cpualu_pkg::OP_ADC) || (op_in.op == cpualu_pkg::OP_SBC))
                 ? flags_in.c : 1'b0;

    // Shared byte adder and subtractor with nibble carries
    assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign nib5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign dif9  = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign nibd5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    // 16-bit add with carry out of bit 11
    assign sum17 = {1'b0, op_in.word_a} + {1'b0, op_in.word_b};
    assign sum13 = {1'b0, op_in.word_a[11:0]} + {1'b0, op_in.word_b[11:0]};

    // Decimal adjust correction
    always_comb begin
        corr = 8'd0;
        if (flags_in.n) begin
            if (flags_in.h) corr = corr | cpualu_pkg::DAA_LO;
            if (flags_in.c) corr = corr | cpualu_pkg::DAA_HI;
            daa_r = a - corr;
        end else begin
            if (flags_in.h || (a[3:0] > cpualu_pkg::BCD_DIG)) corr = corr | cpualu_pkg::DAA_LO;
            if (flags_in.c || (a > cpualu_pkg::BCD_MAX))      corr = corr | cpualu_pkg::DAA_HI;
            daa_r = a + corr;
        end
    end

    // Operation select
    always_comb begin
        r                   = a;
        f                   = flags_in;
        res_out.word_result = 16'd0;
        res_out.cycle_cost  = cpualu_pkg::COST_BYTE;
        case (op_in.op)
            cpualu_pkg::OP_INC: begin
                r   = a + 8'd1;
                f.z = (r == 8'd0);
                f.n = 1'b0;
                f.h = (a[3:0] == 4'hF);
            end
            cpualu_pkg::OP_DEC: begin
                r   = a - 8'd1;
                f.z = (r == 8'd0);
                f.n = 1'b1;
                f.h = (a[3:0] == 4'h0);
            end
            cpualu_pkg::OP_RLCA: begin
                r = {a[6:0], a[7]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            cpualu_pkg::OP_RRCA: begin
                r = {a[0], a[7:1]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            cpualu_pkg::OP_RLA: begin
                r = {a[6:0], flags_in.c};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
            end
            cpualu_pkg::OP_RRA: begin
                r = {flags_in.c, a[7:1]};
                f = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
            end
            cpualu_pkg::OP_DAA: begin
                r   = daa_r;
                f.h = 1'b0;
                f.c = (corr[6:5] != 2'b00);
                f.z = (r == 8'd0);
            end
            cpualu_pkg::OP_ADD16: begin
                res_out.word_result = sum17[15:0];
                res_out.cycle_cost  = cpualu_pkg::COST_WORD;
                f.h = sum13[12];
                f.c = sum17[16];
                f.n = 1'b0;
            end
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: begin
                r = sum9[7:0];
                f = '{z: (sum9[7:0] == 8'd0), n: 1'b0, h: nib5[4], c: sum9[8]};
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP: begin
                // cp keeps the operand, flags as sub
                r = (op_in.op == cpualu_pkg::OP_CP) ? a : dif9[7:0];
                f = '{z: (dif9[7:0] == 8'd0), n: 1'b1, h: nibd5[4], c: dif9[8]};
            end
            cpualu_pkg::OP_AND: begin
                r = a & b;
                f = '{z: ((a & b) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            cpualu_pkg::OP_XOR: begin
                r = a ^ b;
                f = '{z: ((a ^ b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            default: begin
                r = a | b;
                f = '{z: ((a | b) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
        endcase
        res_out.byte_result = r;
        res_out.flags       = f;
    end

endmodule

// File: src/cpu_alu_with_flags.sv
// 8-bit CPU ALU with a persistent flag register (zero, subtract, half-carry,
// carry).
// Input channel s_*: one beat is one operation. s_tuser carries the opcode,
// s_tdata the operands byte_a, byte_b, word_a, word_b from the low bits up.
// Result channel m_*: one beat per operation with the byte result, the
// 16-bit add result, the four flags and the machine cycle cost.
// Pipeline: an accepted beat sits in the input register, is computed in one
// pass and moves to the result register once that is empty or m_tready is
// high. Throughput is one operation per clock while m_tready stays high;
// the flag register is updated as each operation leaves the input stage,
// so the next one sees its flags with no bubble.
// With m_tready low the result register holds; an empty input register
// still takes one more beat, then s_tready drops until the result drains.
// Reset (aresetn low, synchronous) empties both stages and clears all flags.
module cpu_alu_with_flags (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] byte_a, [15:8] byte_b, [31:16] word_a, [47:32] word_b
    input  logic [47:0] s_tdata,
    // [3:0] operation
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] byte_result, [23:8] word_result, [24] zero_flag,
    // [25] subtract_flag, [26] half_carry_flag, [27] carry_flag,
    // [31:28] cycle_cost
    output logic [31:0] m_tdata
);

    logic                 in_valid_reg;
    logic                 in_valid_next;
    cpualu_pkg::alu_in_t  in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    cpualu_pkg::alu_out_t out_data_reg;
    cpualu_pkg::flags_t   flag_reg;
    cpualu_pkg::flags_t   flag_next;
    cpualu_pkg::alu_out_t core_res;
    logic                 advance;
    logic                 s_beat;

    // Stage handshake
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    assign in_valid_next  = s_beat || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);
    assign flag_next      = advance ? core_res.flags : flag_reg;

    cpualu_core u_core (
        .op_in    (in_data_reg),
        .flags_in (flag_reg),
        .res_out  (core_res)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_data_reg.op     <= s_tuser;
            in_data_reg.byte_a <= s_tdata[7:0];
            in_data_reg.byte_b <= s_tdata[15:8];
            in_data_reg.word_a <= s_tdata[31:16];
            in_data_reg.word_b <= s_tdata[47:32];
        end
        if (advance) begin
            out_data_reg <= core_res;
        end
    end

    // Output beat packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_data_reg.cycle_cost,
                       out_data_reg.flags.c, out_data_reg.flags.h,
                       out_data_reg.flags.n, out_data_reg.flags.z,
                       out_data_reg.word_result, out_data_reg.byte_result};

    // Flags leave reset cleared
    a_flag_reset: assert property (@(posedge aclk)
        !aresetn |=> (flag_reg == '0))
        else $error("flags not cleared by reset");

    // Delivered flags match the live flag register while the input stage is empty
    a_flag_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !in_valid_reg) |->
            (m_tdata[27:24] == {flag_reg.c, flag_reg.h, flag_reg.n, flag_reg.z}))
        else $error("result flags disagree with flag register");

    // Cycle cost is either byte or word cost
    a_cost: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:28] == cpualu_pkg::COST_BYTE ||
                      m_tdata[31:28] == cpualu_pkg::COST_WORD))
        else $error("illegal cycle cost");

    // A computed operation always reaches the result register
    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced operation lost");

endmodule
